@@ rtl/srmap_pkg.sv @@
`default_nettype none

package srmap_pkg;

	localparam int MAX_ENTRIES     = 256;
	localparam int IDX_W           = $clog2(MAX_ENTRIES);
	localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
	localparam int SHARD_SIZE_LOG2 = 20;
	localparam int DATA_W          = 64;

	localparam logic [DATA_W-1:0] SHARD_SIZE = DATA_W'(1) << SHARD_SIZE_LOG2;
	localparam logic [DATA_W-1:0] SHARD_MASK = SHARD_SIZE - DATA_W'(1);

	// APB register map: two 8-byte slots selected by paddr bit 3; only slot 0 holds a 64-bit register
	localparam int PADDR_W     = 4;
	localparam int REG_SEL_BIT = 3;
	localparam logic REG_MISS_ADDR = 1'b0;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] offset;
		logic [DATA_W-1:0] address;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		entry_t           data;
	} mem_wr_t;

endpackage

`default_nettype wire

@@ rtl/sorted_range_map_with_shard_length_top.sv @@
`default_nettype none
// Channel   | Handshake               | Payload
// ----------+-------------------------+---------------------------------------------
// request   | in_valid / in_ready     | op, search_offset, map_address, request_len
// result    | out_valid / out_ready   | status, hit, found_address, granted_len
// config    | APB psel/penable/pready | paddr, pwdata, prdata (miss address register)
//
// A request scans the table one entry per cycle through the single read port of
// the entry store and stops at the first entry above the offset or after the last
// entry; an empty table skips the scan. The decide and result states follow. A
// lookup adds the subtract, clip and length states; an insert that moves entries
// passes through the shift state, which moves them up one at a time and then
// places the new entry. The slowest request is a lookup past the last entry of a
// full table, and in_ready rises as its result moves into the output register.
// Reset clears the entry count, the empty address register and out_valid.
// A result waiting on out_ready holds the next request in its result cycle, and
// in_ready stays low until that request's result moves into the output register.

module sorted_range_map_with_shard_length_top (
	input  wire                           clk,
	input  wire                           arst_n,
	// request channel
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire                           op,
	input  wire [srmap_pkg::DATA_W-1:0]   search_offset,
	input  wire [srmap_pkg::DATA_W-1:0]   map_address,
	input  wire [srmap_pkg::DATA_W-1:0]   request_len,
	// result channel
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          status,
	output logic                          hit,
	output logic [srmap_pkg::DATA_W-1:0]  found_address,
	output logic [srmap_pkg::DATA_W-1:0]  granted_len,
	// configuration port
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [srmap_pkg::PADDR_W-1:0]  paddr,
	input  wire [srmap_pkg::DATA_W-1:0]   pwdata,
	output logic [srmap_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);
	import srmap_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_LK_SUB,
		ST_LK_CLIP,
		ST_LK_LEN,
		ST_SHIFT,
		ST_RESULT
	} state_t;

	state_t            state_q;

	// latched request
	logic              op_q;
	logic [DATA_W-1:0] query_q;
	logic [DATA_W-1:0] addr_q;
	logic [DATA_W-1:0] req_q;

	// table bookkeeping
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;       // during scan: entry on rd_data; after: entries <= query
	logic [IDX_W-1:0]  wr_idx_q;
	logic [DATA_W-1:0] prev_off_q;
	logic [DATA_W-1:0] prev_addr_q;
	logic [DATA_W-1:0] next_off_q;
	logic              next_ok_q;

	// lookup arithmetic
	logic [DATA_W-1:0] diff_prev_q;
	logic [DATA_W-1:0] diff_next_q;
	logic [DATA_W-1:0] dist_q;
	logic [DATA_W-1:0] avail_q;

	// staged result and output register
	logic              res_status_q;
	logic              res_hit_q;
	logic [DATA_W-1:0] res_found_q;
	logic [DATA_W-1:0] res_len_q;

	logic [DATA_W-1:0] empty_addr_q;

	mem_wr_t           wr;
	logic [IDX_W-1:0]  rd_idx;
	entry_t            rd_data;

	logic              in_acc;
	logic              cfg_wr;
	logic              out_free;
	logic [CNT_W-1:0]  idx_inc;
	logic              scan_le;
	logic              scan_last;
	logic              ins_match;
	logic              tbl_full;
	logic              lk_hit;
	logic              lk_use_next;

	srmap_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && (paddr[REG_SEL_BIT] == REG_MISS_ADDR);
	assign prdata    = (paddr[REG_SEL_BIT] == REG_MISS_ADDR) ? empty_addr_q : '0;

	assign idx_inc   = idx_q + CNT_W'(1);
	assign scan_le   = (rd_data.offset <= query_q);
	assign scan_last = (idx_inc == count_q);
	assign ins_match = (idx_q != '0) && (prev_off_q == query_q);
	assign tbl_full  = (count_q == CNT_W'(MAX_ENTRIES));
	// hit: query lies less than one shard past the floor entry
	assign lk_hit    = (idx_q != '0) && ((diff_prev_q >> SHARD_SIZE_LOG2) == '0);
	assign lk_use_next = next_ok_q && ((idx_q == '0) || lk_hit);

	// Read address: prefetch the next entry during the scan, the last entry in the
	// decide state, and the entry below the next write slot during the shift.
	always_comb begin
		rd_idx = '0;
		unique case (state_q)
			ST_SCAN:   rd_idx = IDX_W'(idx_inc);
			ST_DECIDE: rd_idx = IDX_W'(count_q - CNT_W'(1));
			ST_SHIFT:  rd_idx = wr_idx_q - IDX_W'(2);
			default:   rd_idx = '0;
		endcase
	end

	// Write port: replace in place, append, move an entry up, or drop the new
	// entry into the hole left by the shift.
	always_comb begin
		wr.en          = 1'b0;
		wr.idx         = IDX_W'(idx_q);
		wr.data.offset  = query_q;
		wr.data.address = addr_q;
		if (state_q == ST_DECIDE && op_q == OP_INSERT) begin
			if (ins_match) begin
				wr.en  = 1'b1;
				wr.idx = IDX_W'(idx_q - CNT_W'(1));
			end else if (!tbl_full && idx_q == count_q) begin
				wr.en = 1'b1;
			end
		end else if (state_q == ST_SHIFT) begin
			wr.en = 1'b1;
			if (wr_idx_q != IDX_W'(idx_q)) begin
				wr.idx  = wr_idx_q;
				wr.data = rd_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			out_valid    <= 1'b0;
			empty_addr_q <= '0;
		end else begin
			if (cfg_wr) begin
				empty_addr_q <= pwdata;
			end
			// raise valid as the staged result moves out, drop it once taken
			if (state_q == ST_RESULT && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q      <= op;
						query_q   <= search_offset;
						addr_q    <= map_address;
						req_q     <= request_len;
						idx_q     <= '0;
						next_ok_q <= 1'b0;
						// empty table: skip the scan
						state_q   <= (count_q == '0) ? ST_DECIDE : ST_SCAN;
					end
				end

				ST_SCAN: begin
					if (scan_le) begin
						prev_off_q  <= rd_data.offset;
						prev_addr_q <= rd_data.address;
						idx_q       <= idx_inc;
						if (scan_last) begin
							state_q <= ST_DECIDE;
						end
					end else begin
						// first entry above the query: hold it as the next entry
						next_off_q <= rd_data.offset;
						next_ok_q  <= 1'b1;
						state_q    <= ST_DECIDE;
					end
				end

				ST_DECIDE: begin
					res_status_q <= STATUS_OK;
					res_hit_q    <= 1'b0;
					res_found_q  <= '0;
					res_len_q    <= '0;
					if (op_q == OP_LOOKUP) begin
						state_q <= ST_LK_SUB;
					end else if (ins_match) begin
						state_q <= ST_RESULT;
					end else if (tbl_full) begin
						res_status_q <= STATUS_FULL;
						state_q      <= ST_RESULT;
					end else if (idx_q == count_q) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_RESULT;
					end else begin
						wr_idx_q <= IDX_W'(count_q);
						state_q  <= ST_SHIFT;
					end
				end

				ST_SHIFT: begin
					if (wr_idx_q == IDX_W'(idx_q)) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_RESULT;
					end else begin
						wr_idx_q <= wr_idx_q - IDX_W'(1);
					end
				end

				ST_LK_SUB: begin
					diff_prev_q <= query_q - prev_off_q;
					diff_next_q <= next_off_q - query_q;
					dist_q      <= SHARD_SIZE - (query_q & SHARD_MASK);
					state_q     <= ST_LK_CLIP;
				end

				ST_LK_CLIP: begin
					res_hit_q   <= lk_hit;
					res_found_q <= lk_hit ? prev_addr_q : empty_addr_q;
					avail_q     <= (lk_use_next && diff_next_q < dist_q) ? diff_next_q : dist_q;
					state_q     <= ST_LK_LEN;
				end

				ST_LK_LEN: begin
					res_len_q <= (req_q < avail_q) ? req_q : avail_q;
					state_q   <= ST_RESULT;
				end

				ST_RESULT: begin
					// hold until the output register frees up
					if (out_free) begin
						status        <= res_status_q;
						hit           <= res_hit_q;
						found_address <= res_found_q;
						granted_len   <= res_len_q;
						state_q       <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count moved by other than one");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q < count_q))
		else $error("scan index past entry count");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_DECIDE || state_q == ST_SHIFT))
		else $error("store write outside insert states");

	a_shift_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (count_q < CNT_W'(MAX_ENTRIES) && idx_q < count_q))
		else $error("shift on a full table or with nothing to move");
`endif

endmodule

`default_nettype wire

@@ rtl/srmap_store.sv @@
`default_nettype none

module srmap_store (
	input  wire                         clk,
	input  srmap_pkg::mem_wr_t          wr,
	input  wire [srmap_pkg::IDX_W-1:0]  rd_idx,
	output srmap_pkg::entry_t           rd_data
);
	import srmap_pkg::*;

	entry_t mem_q [MAX_ENTRIES];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.idx] <= wr.data;
		end
		rd_data <= mem_q[rd_idx];
	end

endmodule

`default_nettype wire

@@ test/tb_sorted_range_map_with_shard_length_top.sv @@
`timescale 1ns / 100ps

module tb_sorted_range_map_with_shard_length_top;
	import srmap_pkg::*;

	// Comfortably longer than the slowest request on a full table
	localparam int SETTLE_CYCLES   = 2 * MAX_ENTRIES + 16;
	// Long receiver stall, single hold-off and worst request, taken several times over
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int HOLD_OFF_CYCLES = 3000;
	localparam int HOLD_OFF_AFTER  = 40;
	// Register index past the map: the write must leave the table state alone
	localparam int UNMAPPED_REG    = 1;

	typedef logic [DATA_W-1:0] word_t;

	typedef struct {
		logic  status;
		logic  hit;
		word_t address;
		word_t granted;
	} map_result_t;

	// Own copy of the sorted table; predicts one result per accepted request
	class range_map_scoreboard;
		word_t         offsets[MAX_ENTRIES];
		word_t         addresses[MAX_ENTRIES];
		int            live_entries;
		word_t         miss_address;
		map_result_t   expected_results[$];
		int            mismatch_count;

		function new();
			live_entries   = 0;
			miss_address   = '0;
			mismatch_count = 0;
		endfunction

		function int entries_at_or_below(word_t q);
			int n;
			n = 0;
			while (n < live_entries && offsets[n] <= q)
				n++;
			return n;
		endfunction

		function void note_request(logic kind, word_t q, word_t addr, word_t len);
			map_result_t r;
			int          n;
			word_t       room;
			n = entries_at_or_below(q);
			r.status  = STATUS_OK;
			r.hit     = 1'b0;
			r.address = '0;
			r.granted = '0;
			if (kind == OP_INSERT) begin
				if (n > 0 && offsets[n-1] == q) begin
					addresses[n-1] = addr;
				end else if (live_entries >= MAX_ENTRIES) begin
					r.status = STATUS_FULL;
				end else begin
					for (int i = live_entries; i > n; i--) begin
						offsets[i]   = offsets[i-1];
						addresses[i] = addresses[i-1];
					end
					offsets[n]   = q;
					addresses[n] = addr;
					live_entries++;
				end
			end else begin
				room      = SHARD_SIZE - (q & SHARD_MASK);
				r.address = miss_address;
				if (n == 0) begin
					if (live_entries > 0 && offsets[0] - q < room)
						room = offsets[0] - q;
				end else if (q - offsets[n-1] < SHARD_SIZE) begin
					r.hit     = 1'b1;
					r.address = addresses[n-1];
					if (n < live_entries && offsets[n] - q < room)
						room = offsets[n] - q;
				end
				r.granted = (len < room) ? len : room;
			end
			expected_results.push_back(r);
		endfunction

		task report_mismatch(string field, word_t got, word_t want);
			mismatch_count++;
			// drop further lines once the log is long enough to diagnose
			if (mismatch_count <= 200)
				$display("mismatch %0d at %0t: %s got %h expected %h",
					mismatch_count, $realtime, field, got, want);
		endtask

		task check_result(map_result_t got);
			map_result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending, address", got.address, '0);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", word_t'(got.status), word_t'(want.status));
				if (got.hit !== want.hit)
					report_mismatch("hit", word_t'(got.hit), word_t'(want.hit));
				if (got.address !== want.address)
					report_mismatch("found_address", got.address, want.address);
				if (got.granted !== want.granted)
					report_mismatch("granted_len", got.granted, want.granted);
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic               op            = OP_LOOKUP;
	word_t              search_offset = '0;
	word_t              map_address   = '0;
	word_t              request_len   = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic               status;
	logic               hit;
	word_t              found_address;
	word_t              granted_len;
	logic               psel          = 1'b0;
	logic               penable       = 1'b0;
	logic               pwrite        = 1'b0;
	logic [PADDR_W-1:0] paddr         = '0;
	word_t              pwdata        = '0;
	word_t              prdata;
	logic               pready;

	range_map_scoreboard tracker = new();

	sorted_range_map_with_shard_length_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.search_offset (search_offset),
		.map_address   (map_address),
		.request_len   (request_len),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.hit           (hit),
		.found_address (found_address),
		.granted_len   (granted_len),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic word_t wide_random();
		return {$urandom, $urandom};
	endfunction

	// Offset of a live entry, or anything when the table is empty
	function automatic word_t stored_offset();
		if (tracker.live_entries == 0)
			return wide_random();
		return tracker.offsets[$urandom_range(tracker.live_entries - 1)];
	endfunction

	// Offset inside the first 128 shards, so that entries sit close together
	function automatic word_t clustered_offset();
		word_t low;
		low = ($urandom_range(3) == 0) ? '0 : (word_t'($urandom) & SHARD_MASK);
		return (word_t'($urandom_range(127)) << SHARD_SIZE_LOG2) | low;
	endfunction

	function automatic word_t pick_insert_offset();
		case ($urandom_range(9))
			0, 1:    return wide_random();
			8:       return '1 - word_t'($urandom_range(1 << 22));
			9:       return stored_offset();
			default: return clustered_offset();
		endcase
	endfunction

	// Queries aim at, just past, a shard past, and just below live entries, or are random or clustered
	function automatic word_t pick_query();
		word_t base;
		base = stored_offset();
		case ($urandom_range(7))
			0:       return wide_random();
			1:       return base;
			2:       return base + word_t'($urandom_range(255));
			3:       return base + (word_t'($urandom) & SHARD_MASK);
			4:       return base + SHARD_SIZE - word_t'($urandom_range(2));
			5:       return base - word_t'($urandom_range(1, 4096));
			default: return clustered_offset();
		endcase
	endfunction

	function automatic word_t pick_length();
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			2:       return word_t'($urandom_range(1, 64));
			3:       return word_t'($urandom) & ((SHARD_SIZE << 1) - 1);
			default: return wide_random();
		endcase
	endfunction

	function automatic word_t pick_address();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? '1 : '0;
		return wide_random();
	endfunction

	// Offer one request after an idle gap; hold valid and payload until accepted
	task automatic send_request(logic kind, word_t q, word_t addr, word_t len, int gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		op            <= kind;
		search_offset <= q;
		map_address   <= addr;
		request_len   <= len;
		do @(posedge clk); while (in_ready !== 1'b1);
		tracker.note_request(kind, q, addr, len);
	endtask

	// Setup phase, then access phase; the register takes the data once pready is seen
	task automatic write_register(int index, word_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(index) << REG_SEL_BIT;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == int'(REG_MISS_ADDR))
			tracker.miss_address = value;
	endtask

	// Drop valid, wait out every pending result, then let the block go quiet
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (tracker.expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_phase(int items, int insert_pct);
		logic kind;
		int   gap;
		for (int k = 0; k < items; k++) begin
			kind = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
			// hold the sender back-to-back for a stretch of every 160 requests
			if (k % 160 < 40)
				gap = 0;
			else if ($urandom_range(9) < 5)
				gap = 0;
			else if ($urandom_range(9) != 0)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(10, 40);
			send_request(kind, (kind == OP_INSERT) ? pick_insert_offset() : pick_query(),
				pick_address(), pick_length(), gap);
		end
	endtask

	// Main sequence: reset, directed requests, then two random phases with
	// a different empty address in each.
	initial begin : stimulus
		word_t first_ofs;
		word_t low_ofs;
		first_ofs = word_t'(5) << SHARD_SIZE_LOG2;
		low_ofs   = (word_t'(3) << SHARD_SIZE_LOG2) + word_t'(16);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_register(REG_MISS_ADDR, '1);

		// Empty table: miss, clipped to the shard end; the top shard leaves one byte
		send_request(OP_LOOKUP, '0, '1, '1, 0);
		send_request(OP_LOOKUP, '1, '0, '1, $urandom_range(2));
		// First entry, then an insert below it, then a replace of the first
		send_request(OP_INSERT, first_ofs, '1, '1, 0);
		send_request(OP_INSERT, low_ofs, '0, '0, $urandom_range(2));
		send_request(OP_INSERT, first_ofs, 64'hA5A5_5A5A_0F0F_F0F0, '0, 0);
		// Below the lowest entry: clip to the distance to that entry
		send_request(OP_LOOKUP, low_ofs - word_t'(16), '0, '1, 0);
		// Hit with a later entry, hit on the last entry at the shard's last byte
		send_request(OP_LOOKUP, low_ofs + word_t'(5), '0, '1, $urandom_range(2));
		send_request(OP_LOOKUP, first_ofs + SHARD_MASK, '1, '1, 0);
		// Exactly one shard past the covering entry: miss
		send_request(OP_LOOKUP, first_ofs + SHARD_SIZE, '0, word_t'(7), 0);
		send_request(OP_LOOKUP, first_ofs + word_t'(3), '0, '0, $urandom_range(2));
		// Entries at both ends of the offset space
		send_request(OP_INSERT, '1, wide_random(), '1, 0);
		send_request(OP_INSERT, '0, 64'h1234, wide_random(), 0);
		send_request(OP_LOOKUP, '1, '0, '1, $urandom_range(2));
		send_request(OP_LOOKUP, word_t'(2) << SHARD_SIZE_LOG2, '0, '1, 0);
		send_request(OP_LOOKUP, '0, '1, word_t'(7), 0);
		send_request(OP_LOOKUP, '1 - SHARD_SIZE, '0, '1, $urandom_range(2));
		send_request(OP_INSERT, low_ofs + word_t'(1), wide_random(), '1, 0);
		drain_and_settle();

		// Unmapped register index first; the random value must not stick
		write_register(UNMAPPED_REG, wide_random());
		write_register(REG_MISS_ADDR, wide_random());
		// Mostly inserts: fill the table up to capacity
		run_random_phase(400, 75);
		drain_and_settle();

		write_register(REG_MISS_ADDR, '0);
		// Full table: refusals, replaces and deep lookups
		run_random_phase(333, 45);
		drain_and_settle();

		if (tracker.mismatch_count == 0 && tracker.expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Result side: random stalls with quiet windows, and one long hold-off
	// once enough results have gone by, so the block backs up into in_ready.
	initial begin : result_sink
		map_result_t got;
		int          stall;
		int          cycle_count;
		int          seen;
		bit          held;
		stall       = 0;
		cycle_count = 0;
		seen        = 0;
		held        = 1'b0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (out_valid === 1'b1 && out_ready) begin
				got.status  = status;
				got.hit     = hit;
				got.address = found_address;
				got.granted = granted_len;
				tracker.check_result(got);
				seen++;
			end
			if (!held && seen == HOLD_OFF_AFTER) begin
				held  = 1'b1;
				stall = HOLD_OFF_CYCLES;
			end else if (stall == 0 && (cycle_count / 2048) % 3 != 0
					&& $urandom_range(3) == 0) begin
				stall = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 3);
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Count cycles with no handshake on any port; end the run if the block hangs
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

endmodule
